/* rtl/core/first_fit_free_list_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define FFA_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define FFA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ffa_pkg.sv */
// Package for the first-fit free-list allocator: heap geometry, codes and
// request/result payload types. Depends on nothing.
package ffa_pkg;

    // Heap geometry.
    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEAP_UNITS   = HEAP_BYTES / ALIGN_BYTES;
    localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
    localparam int UNIT_W       = $clog2(HEAP_UNITS);
    localparam int LINK_W       = UNIT_W + 1;
    localparam int SIZE_W       = $clog2(HEAP_BYTES) + 1;

    // Field widths of the request and result.
    localparam int OP_W   = 2;
    localparam int REQ_W  = 17;
    localparam int ADDR_W = 16;
    localparam int OUTC_W = 3;

    // Width of the aligned size plus header.
    localparam int NEED_W = ((REQ_W > SIZE_W) ? REQ_W : SIZE_W) + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;

    // Outcome codes.
    localparam logic [OUTC_W-1:0] OUT_ALLOCATED = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_FREED     = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_REUSED    = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_MOVED     = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_NO_FIT    = 3'd4;
    localparam logic [OUTC_W-1:0] OUT_NOTHING   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] block_address;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [OUTC_W-1:0] outcome;
        logic [REQ_W-1:0]  copy_length;
    } result_t;

endpackage

/* rtl/core/first_fit_free_list_allocator.sv */
// First-fit free-list allocator top level: sequencer, header stores, result register.
// Depends on ffa_pkg and first_fit_free_list_allocator_defines.svh.
`include "first_fit_free_list_allocator_defines.svh"

// A request is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high, and the receiver
// cannot stall it, so it must capture the result in that cycle. A request that
// needs no store access (bad pointer, zero-size allocate, unknown opcode)
// finishes straight from idle; free pushes the block in S_PUSH; an in-place
// reallocate reads the old size (S_RDOLD, S_OLDCHK); allocate walks the list
// (S_RDCUR, S_CHECK per block visited), splits in S_SPLIT when needed, and
// relinks and reports in S_LINK; a walk that finds no fit reports from S_RDCUR.
// A moving reallocate adds the size lookup before the walk and S_PUSH after it.
// The free-list walk sets the rate: each block visited costs a registered
// read of the header stores followed by a compare. The stores need no clearing
// pass after reset.
module first_fit_free_list_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ffa_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output ffa_pkg::result_t  result
);
    import ffa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RDOLD  = 8'b0000_0010,
        S_OLDCHK = 8'b0000_0100,
        S_RDCUR  = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_SPLIT  = 8'b0010_0000,
        S_LINK   = 8'b0100_0000,
        S_PUSH   = 8'b1000_0000
    } state_t;

    // Header stores: block size and next-free link, one entry per unit.
    logic [SIZE_W-1:0] size_mem [HEAP_UNITS];
    logic [LINK_W-1:0] link_mem [HEAP_UNITS];

    state_t            state_reg, state_next;
    logic [REQ_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic              move_reg, move_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] succ_reg, succ_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [UNIT_W-1:0] tail_reg, tail_next;
    logic [SIZE_W-1:0] rest_reg, rest_next;
    logic [LINK_W-1:0] linkcur_reg, linkcur_next;
    logic              split_reg, split_next;
    logic [REQ_W-1:0]  old_reg, old_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic              size0_set_reg, link0_set_reg;
    logic              done_reg;
    result_t           result_reg;

    // Store ports.
    logic              size_we, link_we;
    logic [UNIT_W-1:0] size_waddr, link_waddr, rd_addr;
    logic [SIZE_W-1:0] size_wdata, size_q, size_rd;
    logic [LINK_W-1:0] link_wdata, link_q, link_rd;
    logic              size_dflt_q, link_dflt_q;

    // Finishing a request.
    logic              fin;
    result_t           fin_res;

    // Pointer decode of the incoming request.
    logic [ADDR_W-1:0] ptr_off;
    logic              ptr_ok;
    logic [UNIT_W-1:0] unit_in;

    // Shared size arithmetic.
    logic [NEED_W-1:0] rsize, need, tail_sum;
    logic              fits, split;
    logic [SIZE_W-1:0] rest, old_pay;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Entry 0 holds the whole heap until it is first written.
    assign size_rd = size_dflt_q ? SIZE_W'(HEAP_BYTES) : size_q;
    assign link_rd = link_dflt_q ? LINK_W'(HEAP_UNITS) : link_q;

    // Pointer validity: at least a header in, on a unit boundary, inside the heap.
    always_comb
    begin
        ptr_off = request.block_address - ADDR_W'(HEADER_BYTES);
        unit_in = UNIT_W'(ptr_off >> ALIGN_SHIFT);
        ptr_ok  = (request.block_address >= ADDR_W'(HEADER_BYTES))
                  && (ptr_off[ALIGN_SHIFT-1:0] == '0)
                  && ((ptr_off >> ALIGN_SHIFT) < ADDR_W'(HEAP_UNITS));
    end

    // Aligned request size, block need, split test and old payload size.
    always_comb
    begin
        rsize    = ((NEED_W'(size_reg) + NEED_W'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT)
                   << ALIGN_SHIFT;
        need     = rsize + NEED_W'(HEADER_BYTES);
        fits     = NEED_W'(size_rd) >= need;
        rest     = size_rd - SIZE_W'(need);
        tail_sum = NEED_W'(cur_reg) + (need >> ALIGN_SHIFT);
        split    = (rest >= SIZE_W'(HEADER_BYTES + ALIGN_BYTES))
                   && (tail_sum < NEED_W'(HEAP_UNITS));
        old_pay  = (size_rd > SIZE_W'(HEADER_BYTES))
                   ? size_rd - SIZE_W'(HEADER_BYTES) : '0;
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        size_next    = size_reg;
        ptr_next     = ptr_reg;
        unit_next    = unit_reg;
        move_next    = move_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        succ_next    = succ_reg;
        steps_next   = steps_reg;
        tail_next    = tail_reg;
        rest_next    = rest_reg;
        linkcur_next = linkcur_reg;
        split_next   = split_reg;
        old_next     = old_reg;
        head_next    = head_reg;
        size_we      = 1'b0;
        size_waddr   = tail_reg;
        size_wdata   = rest_reg;
        link_we      = 1'b0;
        link_waddr   = tail_reg;
        link_wdata   = linkcur_reg;
        rd_addr      = unit_reg;
        fin          = 1'b0;
        fin_res      = '{result_address: '0, outcome: OUT_NOTHING, copy_length: '0};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    size_next  = request.request_size;
                    ptr_next   = request.block_address;
                    unit_next  = unit_in;
                    move_next  = 1'b0;
                    cur_next   = head_reg;
                    prev_next  = LINK_W'(HEAP_UNITS);
                    steps_next = '0;
                    case (request.opcode)
                        OP_ALLOC:
                        begin
                            if (request.request_size == '0)
                                fin = 1'b1;
                            else
                                state_next = S_RDCUR;
                        end
                        OP_FREE:
                        begin
                            if (request.block_address == '0 || !ptr_ok)
                                fin = 1'b1;
                            else
                                state_next = S_PUSH;
                        end
                        OP_REALLOC:
                        begin
                            if (request.block_address == '0)
                            begin
                                if (request.request_size == '0)
                                    fin = 1'b1;
                                else
                                    state_next = S_RDCUR;
                            end
                            else if (!ptr_ok)
                                fin = 1'b1;
                            else if (request.request_size == '0)
                                state_next = S_PUSH;
                            else
                                state_next = S_RDOLD;
                        end
                        default:
                            fin = 1'b1;
                    endcase
                end
            end

            // Look up the size of the block being reallocated.
            S_RDOLD:
            begin
                rd_addr    = unit_reg;
                state_next = S_OLDCHK;
            end

            S_OLDCHK:
            begin
                if (rsize <= NEED_W'(old_pay))
                begin
                    fin     = 1'b1;
                    fin_res = '{result_address: ptr_reg, outcome: OUT_REUSED,
                                copy_length: '0};
                end
                else
                begin
                    old_next   = REQ_W'(old_pay);
                    move_next  = 1'b1;
                    state_next = S_RDCUR;
                end
            end

            // Fetch the header of the current free block, or give up.
            S_RDCUR:
            begin
                rd_addr = cur_reg[UNIT_W-1:0];
                if (steps_reg == LINK_W'(HEAP_UNITS) || cur_reg >= LINK_W'(HEAP_UNITS))
                begin
                    fin        = 1'b1;
                    fin_res    = '{result_address: '0, outcome: OUT_NO_FIT, copy_length: '0};
                    state_next = S_IDLE;
                end
                else
                    state_next = S_CHECK;
            end

            // First-fit test; advance along the list when the block is too small.
            S_CHECK:
            begin
                if (fits)
                begin
                    rest_next    = rest;
                    tail_next    = UNIT_W'(tail_sum);
                    linkcur_next = link_rd;
                    split_next   = split;
                    succ_next    = split ? LINK_W'(tail_sum) : link_rd;
                    state_next   = split ? S_SPLIT : S_LINK;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_RDCUR;
                end
            end

            // Write the header of the split-off tail block.
            S_SPLIT:
            begin
                size_we    = 1'b1;
                size_waddr = tail_reg;
                size_wdata = rest_reg;
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = linkcur_reg;
                state_next = S_LINK;
            end

            // Trim the taken block and unlink it from the list.
            S_LINK:
            begin
                size_we    = split_reg;
                size_waddr = cur_reg[UNIT_W-1:0];
                size_wdata = SIZE_W'(need);
                if (prev_reg < LINK_W'(HEAP_UNITS))
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[UNIT_W-1:0];
                    link_wdata = succ_reg;
                end
                else
                    head_next = succ_reg;
                if (move_reg)
                    state_next = S_PUSH;
                else
                begin
                    fin        = 1'b1;
                    fin_res    = '{result_address: ADDR_W'((NEED_W'(cur_reg) << ALIGN_SHIFT)
                                                   + NEED_W'(HEADER_BYTES)),
                                   outcome: OUT_ALLOCATED, copy_length: '0};
                    state_next = S_IDLE;
                end
            end

            // Push a freed block onto the head of the list.
            S_PUSH:
            begin
                link_we    = 1'b1;
                link_waddr = unit_reg;
                link_wdata = head_reg;
                head_next  = LINK_W'(unit_reg);
                fin        = 1'b1;
                state_next = S_IDLE;
                if (move_reg)
                    fin_res = '{result_address: ADDR_W'((NEED_W'(cur_reg) << ALIGN_SHIFT)
                                                + NEED_W'(HEADER_BYTES)),
                                outcome: OUT_MOVED, copy_length: old_reg};
                else
                    fin_res = '{result_address: '0, outcome: OUT_FREED, copy_length: '0};
            end

            default:
                state_next = S_IDLE;
        endcase

        if (fin)
            state_next = S_IDLE;
    end

    // Header store access with registered read data.
    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_waddr] <= size_wdata;
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        size_q <= size_mem[rd_addr];
        link_q <= link_mem[rd_addr];
    end

    // Control state, store default flags and done flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            size0_set_reg <= 1'b0;
            link0_set_reg <= 1'b0;
            size_dflt_q   <= 1'b0;
            link_dflt_q   <= 1'b0;
            done_reg      <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            done_reg    <= fin;
            steps_reg   <= steps_next;
            size_dflt_q <= (rd_addr == '0) && !size0_set_reg;
            link_dflt_q <= (rd_addr == '0) && !link0_set_reg;
            if (size_we && size_waddr == '0)
                size0_set_reg <= 1'b1;
            if (link_we && link_waddr == '0)
                link0_set_reg <= 1'b1;
        end
    end

    // Working registers of the current request and the result register.
    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        ptr_reg     <= ptr_next;
        unit_reg    <= unit_next;
        move_reg    <= move_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        succ_reg    <= succ_next;
        tail_reg    <= tail_next;
        rest_reg    <= rest_next;
        linkcur_reg <= linkcur_next;
        split_reg   <= split_next;
        old_reg     <= old_next;
        if (fin)
            result_reg <= fin_res;
    end

    // An accepted request either finishes at once or keeps the block busy.
    `FFA_CHECK_NEXT(a_accept_progress, start && !busy, busy || done, "request accepted but dropped")

    // A result is shown only once the sequencer is back to idle.
    `FFA_CHECK_NOW(a_done_idle, done, !busy, "result shown while still busy")

    // Only a moved block reports a copy length.
    `FFA_CHECK_NOW(a_copy_moved, done && result.outcome != OUT_MOVED, result.copy_length == '0, "copy length without move")

    // The walk never goes past the bound on list length.
    `FFA_CHECK_NOW(a_steps_bound, busy, steps_reg <= LINK_W'(HEAP_UNITS), "free-list walk overran")

endmodule

/* bench/ffa_scoreboard_pkg.sv */
// Scoreboard for the first-fit free-list allocator bench: a predictor that mirrors the
// heap headers and a queue of the results that accepted requests must produce.
// Depends on ffa_pkg for the heap geometry, the codes and the payload types.
`timescale 1ns / 100ps

package ffa_scoreboard_pkg;

    import ffa_pkg::*;

    class alloc_scoreboard;

        // Mirror of the header stores; entries read only after the bench has written them.
        logic [SIZE_W-1:0] blk_size [HEAP_UNITS];
        logic [LINK_W-1:0] next_blk [HEAP_UNITS];
        logic [LINK_W-1:0] free_list_head;

        // Results owed by the block, oldest first.
        result_t expected_results[$];
        int      errors;

        function new();
            blk_size[0]    = SIZE_W'(HEAP_BYTES);
            next_blk[0]    = LINK_W'(HEAP_UNITS);
            free_list_head = '0;
            errors         = 0;
        endfunction

        function int unsigned align_up(int unsigned n);
            return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        endfunction

        // Unit index behind a payload offset, or HEAP_UNITS when the pointer is bad.
        function int unsigned unit_at(int unsigned addr);
            int unsigned off;
            if (addr < HEADER_BYTES)
                return HEAP_UNITS;
            off = addr - HEADER_BYTES;
            if (off % ALIGN_BYTES != 0)
                return HEAP_UNITS;
            off = off / ALIGN_BYTES;
            return (off < HEAP_UNITS) ? off : HEAP_UNITS;
        endfunction

        function logic [ADDR_W-1:0] payload_at(int unsigned unit);
            return ADDR_W'(unit * ALIGN_BYTES + HEADER_BYTES);
        endfunction

        // First-fit walk; unlinks the block found and splits off a usable tail.
        function int unsigned first_fit(int unsigned size);
            int unsigned need;
            int unsigned prev;
            int unsigned cur;
            int unsigned have;
            int unsigned rest;
            int unsigned tail;
            int unsigned succ;
            need = align_up(size) + HEADER_BYTES;
            prev = HEAP_UNITS;
            cur  = free_list_head;
            for (int steps = 0; steps < HEAP_UNITS && cur < HEAP_UNITS; steps++) begin
                have = blk_size[cur];
                if (have >= need) begin
                    rest = have - need;
                    tail = cur + need / ALIGN_BYTES;
                    if (rest >= HEADER_BYTES + ALIGN_BYTES && tail < HEAP_UNITS) begin
                        blk_size[tail] = SIZE_W'(rest);
                        next_blk[tail] = next_blk[cur];
                        blk_size[cur]  = SIZE_W'(need);
                        succ = tail;
                    end
                    else begin
                        succ = next_blk[cur];
                    end
                    if (prev < HEAP_UNITS)
                        next_blk[prev] = LINK_W'(succ);
                    else
                        free_list_head = LINK_W'(succ);
                    return cur;
                end
                prev = cur;
                cur  = next_blk[cur];
            end
            return HEAP_UNITS;
        endfunction

        function void push_free(int unsigned unit);
            next_blk[unit] = free_list_head;
            free_list_head = LINK_W'(unit);
        endfunction

        function result_t allocate_block(int unsigned size);
            result_t     e;
            int unsigned u;
            e = '0;
            e.outcome = OUT_NOTHING;
            if (size == 0)
                return e;
            u = first_fit(size);
            if (u >= HEAP_UNITS) begin
                e.outcome = OUT_NO_FIT;
            end
            else begin
                e.result_address = payload_at(u);
                e.outcome        = OUT_ALLOCATED;
            end
            return e;
        endfunction

        function result_t release_block(int unsigned addr);
            result_t     e;
            int unsigned u;
            e = '0;
            e.outcome = OUT_NOTHING;
            u = unit_at(addr);
            if (addr != 0 && u < HEAP_UNITS) begin
                push_free(u);
                e.outcome = OUT_FREED;
            end
            return e;
        endfunction

        // Works out the result of one accepted request and queues it.
        function result_t predict_result(request_t r);
            result_t     e;
            int unsigned u;
            int unsigned nu;
            int unsigned bs;
            int unsigned old;
            e = '0;
            e.outcome = OUT_NOTHING;
            case (r.opcode)
                OP_ALLOC: e = allocate_block(r.request_size);
                OP_FREE:  e = release_block(r.block_address);
                OP_REALLOC:
                begin
                    if (r.block_address == 0) begin
                        e = allocate_block(r.request_size);
                    end
                    else if (r.request_size == 0) begin
                        e = release_block(r.block_address);
                    end
                    else begin
                        u = unit_at(r.block_address);
                        if (u < HEAP_UNITS) begin
                            bs  = blk_size[u];
                            old = (bs > HEADER_BYTES) ? bs - HEADER_BYTES : 0;
                            if (align_up(r.request_size) <= old) begin
                                e.result_address = r.block_address;
                                e.outcome        = OUT_REUSED;
                            end
                            else begin
                                nu = first_fit(r.request_size);
                                if (nu < HEAP_UNITS) begin
                                    e.result_address = payload_at(nu);
                                    e.outcome        = OUT_MOVED;
                                    e.copy_length    = REQ_W'(old);
                                    push_free(u);
                                end
                                else begin
                                    e.outcome = OUT_NO_FIT;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            expected_results.push_back(e);
            return e;
        endfunction

        // Compares one result from the block against the oldest outstanding one.
        function void check_result(result_t got);
            result_t e;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.result_address !== e.result_address) begin
                $display("%0t: result_address expected %h, got %h",
                         $time, e.result_address, got.result_address);
                errors++;
            end
            if (got.outcome !== e.outcome) begin
                $display("%0t: outcome expected %0d, got %0d", $time, e.outcome, got.outcome);
                errors++;
            end
            if (got.copy_length !== e.copy_length) begin
                $display("%0t: copy_length expected %h, got %h",
                         $time, e.copy_length, got.copy_length);
                errors++;
            end
        endfunction

    endclass

endpackage

/* bench/tb_first_fit_free_list_allocator.sv */
// Top-level bench for the first-fit free-list allocator: directed and random requests,
// random idle gaps, a stall watchdog and a final verdict.
// Depends on ffa_pkg, ffa_scoreboard_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_first_fit_free_list_allocator;

    import ffa_pkg::*;
    import ffa_scoreboard_pkg::*;

    // The opcode value the block has no operation for.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Useful requests in the random part, and the window of it that runs without gaps.
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;

    // A walk over a full cyclic list visits every unit; allow that four times over.
    localparam int STALL_LIMIT = 4 * (2 * HEAP_UNITS + 16);

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    alloc_scoreboard    heap_sb;
    logic [ADDR_W-1:0]  live_blocks[$];
    bit                 quiet = 1'b0;
    int                 idle_cycles = 0;

    first_fit_free_list_allocator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Free-running clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Every result is checked in the one cycle it is shown.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            heap_sb.check_result(result);
    end

    // Watchdog: the run ends if no request is taken and no result shows for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic request_t make_request(logic [OP_W-1:0] op, int unsigned size,
                                              int unsigned addr);
        request_t r;
        r.opcode        = op;
        r.request_size  = REQ_W'(size);
        r.block_address = ADDR_W'(addr);
        return r;
    endfunction

    // Mostly small sizes so that free-list walks stay short; a few reach the whole heap.
    function automatic int unsigned pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return $urandom_range(1, 64);
        else if (roll < 80)
            return $urandom_range(65, 512);
        else if (roll < 95)
            return $urandom_range(513, 4096);
        else if (roll < 99)
            return $urandom_range(4097, 32768);
        else
            return $urandom_range(32769, HEAP_BYTES);
    endfunction

    // A pointer that is nonzero but below the header or off the unit grid.
    function automatic logic [ADDR_W-1:0] bad_pointer();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        if ($urandom_range(3) == 0)
            a = ADDR_W'($urandom_range(1, HEADER_BYTES - 1));
        else if (a[ALIGN_SHIFT-1:0] == '0)
            a[ALIGN_SHIFT-1:0] = ALIGN_SHIFT'($urandom_range(1, ALIGN_BYTES - 1));
        return a;
    endfunction

    // Sends one request, notes it when taken and keeps the list of live blocks current.
    task automatic issue(input request_t r, output result_t e);
        int gap;
        int pos;
        bit was_live;
        gap = 0;
        pos = -1;
        was_live = 1'b0;
        if (!quiet && $urandom_range(99) < 30)
            gap = $urandom_range(1, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= r;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        e = heap_sb.predict_result(r);

        // A free or reallocate of a live block takes it off the list until the result says.
        if ((r.opcode == OP_FREE || r.opcode == OP_REALLOC) && r.block_address != 0) begin
            foreach (live_blocks[k])
                if (pos < 0 && live_blocks[k] == r.block_address)
                    pos = k;
            if (pos >= 0) begin
                was_live = 1'b1;
                live_blocks.delete(pos);
            end
        end
        if (e.outcome == OUT_ALLOCATED || e.outcome == OUT_MOVED)
            live_blocks.push_back(e.result_address);
        else if (e.outcome == OUT_REUSED || (e.outcome == OUT_NO_FIT && was_live))
            live_blocks.push_back(r.block_address);
    endtask

    // Field extremes, every operation and the corner cases of each.
    task automatic directed_checks();
        result_t           e;
        logic [ADDR_W-1:0] blk_a;
        logic [ADDR_W-1:0] blk_b;
        logic [ADDR_W-1:0] blk_c;
        logic [ADDR_W-1:0] blk_d;
        issue(make_request(OP_ALLOC, 0, 0), e);
        issue(make_request(OP_ALLOC, HEAP_BYTES, 16'hFFFF), e);
        issue(make_request(OP_ALLOC, 1, 0), e);
        blk_a = e.result_address;
        issue(make_request(OP_ALLOC, 32, 0), e);
        blk_b = e.result_address;
        issue(make_request(OP_ALLOC, 100, 0), e);
        blk_c = e.result_address;

        // Null, below-header and misaligned frees, then the unused opcode.
        issue(make_request(OP_FREE, 0, 0), e);
        issue(make_request(OP_FREE, 0, 8), e);
        issue(make_request(OP_FREE, 0, 21), e);
        issue(make_request(OP_UNUSED, HEAP_BYTES, 16'hFFFF), e);

        // Reallocate of null acts as allocate; bad pointers do nothing.
        issue(make_request(OP_REALLOC, 0, 0), e);
        issue(make_request(OP_REALLOC, 40, 0), e);
        blk_d = e.result_address;
        issue(make_request(OP_REALLOC, 5, 16'hFFFF), e);
        issue(make_request(OP_REALLOC, 0, 9), e);

        // In place, moved, and a move that finds no room.
        issue(make_request(OP_REALLOC, 30, blk_b), e);
        issue(make_request(OP_REALLOC, 33, blk_b), e);
        issue(make_request(OP_REALLOC, HEAP_BYTES, blk_c), e);

        // A freed block too small to split is handed over whole.
        issue(make_request(OP_FREE, 0, blk_a), e);
        issue(make_request(OP_FREE, 0, blk_c), e);
        issue(make_request(OP_ALLOC, 90, 0), e);

        // Reallocate to size zero frees; the next small request splits that block.
        issue(make_request(OP_REALLOC, 0, blk_d), e);
        issue(make_request(OP_ALLOC, 8, 0), e);
    endtask

    // Well-formed traffic on live blocks, with some noise; noise is flagged as not useful.
    task automatic random_request(output request_t r, output bit useful);
        int roll;
        roll   = $urandom_range(99);
        useful = 1'b1;
        if (live_blocks.size() > 96 && roll < 42)
            roll = roll + 28;
        r = make_request(OP_ALLOC, pick_size(), $urandom_range(0, 16'hFFFF));
        if (roll >= 42 && roll < 88 && live_blocks.size() > 0) begin
            r.block_address = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            if (roll < 70) begin
                r.opcode = OP_FREE;
            end
            else begin
                r.opcode = OP_REALLOC;
                if ($urandom_range(19) == 0)
                    r.request_size = '0;
            end
        end
        else if (roll >= 88) begin
            useful = 1'b0;
            case ($urandom_range(4))
                0: r.opcode = OP_UNUSED;
                1:
                begin
                    r.opcode        = OP_FREE;
                    r.block_address = bad_pointer();
                end
                2:
                begin
                    r.opcode        = OP_REALLOC;
                    r.block_address = bad_pointer();
                    if ($urandom_range(3) == 0)
                        r.request_size = '0;
                end
                3: r.request_size = '0;
                default:
                begin
                    r.opcode        = OP_REALLOC;
                    r.block_address = '0;
                    useful          = 1'b1;
                end
            endcase
        end
    endtask

    // A double free turns the list into a loop; a request nothing in the loop can hold
    // must walk the full step bound and report no fit.
    task automatic cyclic_list_check();
        result_t           e;
        logic [ADDR_W-1:0] victim;
        if (live_blocks.size() == 0)
            issue(make_request(OP_ALLOC, 8, 0), e);
        if (live_blocks.size() > 0) begin
            victim = live_blocks[0];
            issue(make_request(OP_FREE, 0, victim), e);
            issue(make_request(OP_FREE, 0, victim), e);
            issue(make_request(OP_ALLOC, 60000, 0), e);
            issue(make_request(OP_ALLOC, 1, 0), e);
        end
    endtask

    // Main sequence: reset, directed, random, double free, drain and verdict.
    initial
    begin
        request_t r;
        result_t  e;
        bit       useful;
        int       sent;
        heap_sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = (sent >= QUIET_FIRST && sent < QUIET_LAST);
            random_request(r, useful);
            issue(r, e);
            if (useful)
                sent++;
        end
        quiet = 1'b0;

        cyclic_list_check();
        start <= 1'b0;

        while (heap_sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (heap_sb.errors == 0 && heap_sb.expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
